[rtl/core/assert_macros.svh]
// Assertion macros used by the melody tone sequencer RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked property, masked while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);
// Checked property, live through reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/mts_pkg.sv]
// Shared types and constants for the melody tone sequencer.
// No dependencies.
package mts_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam int OP_W     = 3;
	localparam int IDX_W    = 6;
	localparam int PERIOD_W = 16;
	localparam int TICKS_W  = 16;
	localparam int DUTY_W   = 15;
	localparam int POS_W    = 7;
	localparam int CNT_W    = 17;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
	localparam logic [OP_W-1:0] OP_START = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
	localparam logic [OP_W-1:0] OP_TONE  = 3'd4;

	localparam logic REG_SONG_LENGTH = 1'b0;

	// One table entry: duration in the upper half, period in the lower
	typedef struct packed {
		logic [TICKS_W-1:0]  dur;
		logic [PERIOD_W-1:0] per;
	} mts_entry_t;

	// One result beat, laid out as it goes on the output tdata
	typedef struct packed {
		logic                done;
		logic [DUTY_W-1:0]   duty;
		logic [PERIOD_W-1:0] period;
	} mts_res_t;

	function automatic int addr_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

[rtl/core/mts_table.sv]
// Note table: one write port, two registered read ports.
// Depends on mts_pkg.
module mts_table
	import mts_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = addr_width(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  mts_entry_t       wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output mts_entry_t       rd_data_a,
	output mts_entry_t       rd_data_b
);

	mts_entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

[rtl/core/mts_exec.sv]
// Sequencer state (position, tick count, tone) and its next-state logic.
// Depends on mts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mts_exec
	import mts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [OP_W-1:0]     op,
	input  logic [PERIOD_W-1:0] tone_period,
	input  mts_entry_t          rd_a,
	input  logic                rd_a_ok,
	input  mts_entry_t          rd_b,
	input  logic                rd_b_ok,
	input  logic [POS_W-1:0]    song_length,
	output logic [POS_W-1:0]    pos_fwd,
	output mts_res_t            res
);

	logic [POS_W-1:0]    pos_q, pos_d, pos_inc;
	logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc, dur_ext, dur_inc;
	logic [PERIOD_W-1:0] period_q, period_d, dur, per_next;
	logic [DUTY_W-1:0]   duty_q, duty_d;
	logic                finished;

	assign dur      = rd_a_ok ? rd_a.dur : '0;
	assign per_next = rd_b_ok ? rd_b.per : '0;
	assign dur_ext  = {1'b0, dur};
	assign dur_inc  = dur_ext + CNT_W'(1);
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign pos_inc  = pos_q + POS_W'(1);
	assign finished = (pos_q >= song_length);

	always_comb begin
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		period_d = period_q;
		duty_d   = duty_q;
		case (op)
			OP_TICK: begin
				if (finished) begin
					period_d = '0;
					duty_d   = '0;
				end else if (cnt_inc == dur_ext) begin
					// gap tick: silence the period, keep duty
					cnt_d    = cnt_inc;
					period_d = '0;
				end else if (cnt_inc == dur_inc) begin
					pos_d = pos_inc;
					cnt_d = '0;
					if (pos_inc < song_length) begin
						period_d = per_next;
						duty_d   = per_next[PERIOD_W-1:1];
					end else begin
						period_d = '0;
						duty_d   = '0;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			OP_START: begin
				// port b reads entry zero for this op
				pos_d    = '0;
				cnt_d    = '0;
				period_d = per_next;
				duty_d   = per_next[PERIOD_W-1:1];
			end
			OP_STOP: begin
				pos_d = song_length;
			end
			OP_TONE: begin
				period_d = tone_period;
				duty_d   = tone_period[PERIOD_W-1:1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cnt_q    <= '0;
			period_q <= '0;
			duty_q   <= '0;
		end else if (adv) begin
			pos_q    <= pos_d;
			cnt_q    <= cnt_d;
			period_q <= period_d;
			duty_q   <= duty_d;
		end
	end

	// forward the position the next beat will see to the table address
	assign pos_fwd    = adv ? pos_d : pos_q;
	assign res.period = period_d;
	assign res.duty   = duty_d;
	assign res.done   = (pos_d >= song_length);

	`ASSERT_RST(a_start_rewinds, clk, arst_n, adv && op == OP_START |=> pos_q == '0 && cnt_q == '0, "start did not rewind")
	`ASSERT_RST(a_finished_silent, clk, arst_n, adv && op == OP_TICK && finished |=> period_q == '0 && duty_q == '0, "finished song not silent")
	`ASSERT_RST(a_write_keeps_state, clk, arst_n, adv && op == OP_WRITE |=> $stable(pos_q) && $stable(cnt_q) && $stable(period_q), "table write moved state")
	`ASSERT_RST(a_advance_clears, clk, arst_n, adv && op == OP_TICK && !finished && cnt_inc == dur_inc |=> cnt_q == '0, "advance kept tick count")

endmodule

[rtl/core/melody_tone_sequencer_unit.sv]
// Melody tone sequencer top level: stream handshake, config register, table, state.
// Depends on mts_pkg, mts_table and mts_exec.
//
// channel  | dir | beat                                   | sideband
// s_axis   | in  | op, entry_index, tone_period, tone_ticks | -
// m_axis   | out | pwm_period, pwm_duty, song_done          | -
// apb      | cfg | song_length at byte address 0            | pready tied high
//
// One beat per cycle unless m_axis stalls; a beat is registered on accept, its result when it
// executes. The table is read on the accept edge with the position forwarded from the beat in
// execution, so each beat sees the state its predecessor leaves; table writes land on their
// own accept edge. Reset clears position, count, tone and song_length; the table holds no
// reset value. A stalled output holds the beat in execution.
module melody_tone_sequencer_unit
	import mts_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [2:0] op, [8:3] entry_index, [24:9] tone_period, [40:25] tone_ticks, [47:41] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] pwm_period, [30:16] pwm_duty, [31] song_done
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	localparam int AW = addr_width(TABLE_DEPTH);

	logic [OP_W-1:0]     in_op;
	logic [IDX_W-1:0]    in_idx;
	logic [PERIOD_W-1:0] in_period;
	logic [TICKS_W-1:0]  in_ticks;

	logic                accept, adv;
	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic                rd_a_ok_s1, rd_b_ok_s1;

	logic [POS_W-1:0]    pos_fwd, pos_a, pos_b;
	logic                wr_en;
	mts_entry_t          wr_data, rd_a, rd_b;
	mts_res_t            res;

	logic [POS_W-1:0]    song_length_q;
	logic                out_valid_q;
	mts_res_t            out_q;

	assign in_op     = s_axis_tdata[2:0];
	assign in_idx    = s_axis_tdata[8:3];
	assign in_period = s_axis_tdata[24:9];
	assign in_ticks  = s_axis_tdata[40:25];

	// execute when the output register is free or being drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign pos_a = pos_fwd;
	assign pos_b = (in_op == OP_START) ? '0 : pos_fwd + POS_W'(1);

	assign wr_en       = accept && (in_op == OP_WRITE) && (32'(in_idx) < TABLE_DEPTH);
	assign wr_data.dur = in_ticks;
	assign wr_data.per = in_period;

	mts_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (AW'(in_idx)),
		.wr_data  (wr_data),
		.rd_en    (accept),
		.rd_addr_a(AW'(pos_a)),
		.rd_addr_b(AW'(pos_b)),
		.rd_data_a(rd_a),
		.rd_data_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= in_op;
			period_s1  <= in_period;
			rd_a_ok_s1 <= (32'(pos_a) < TABLE_DEPTH);
			rd_b_ok_s1 <= (32'(pos_b) < TABLE_DEPTH);
		end
	end

	mts_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.op         (op_s1),
		.tone_period(period_s1),
		.rd_a       (rd_a),
		.rd_a_ok    (rd_a_ok_s1),
		.rd_b       (rd_b),
		.rd_b_ok    (rd_b_ok_s1),
		.song_length(song_length_q),
		.pos_fwd    (pos_fwd),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// config register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_length_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SONG_LENGTH) begin
			song_length_q <= pwdata[POS_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SONG_LENGTH) ? APB_DW'(song_length_q) : '0;

endmodule

[tb/melody_tone_sequencer_unit_tb.sv]
// Self-checking testbench for melody_tone_sequencer_unit: directed and random beats,
// random stalls on both streams, song_length set over APB between phases.
// Depends on mts_pkg and the melody_tone_sequencer_unit RTL.
module melody_tone_sequencer_unit_tb;
	import mts_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 150;
	localparam logic [APB_AW-1:0] LEN_ADDR = {REG_SONG_LENGTH, 2'b00};

	// Input beat, laid out as on s_axis_tdata (op in the lowest bits)
	typedef struct packed {
		logic [IN_DATA_W-41-1:0] pad;
		logic [TICKS_W-1:0]      ticks;
		logic [PERIOD_W-1:0]     period;
		logic [IDX_W-1:0]        entry;
		logic [OP_W-1:0]         op;
	} tone_beat_t;

	// Tracks the sequencer state and queues the tone each accepted beat leaves behind
	class tone_score;
		logic [POS_W-1:0]    song_len;
		logic [PERIOD_W-1:0] per_tab [TABLE_DEPTH_DEF];
		logic [TICKS_W-1:0]  dur_tab [TABLE_DEPTH_DEF];
		bit                  written [TABLE_DEPTH_DEF];
		logic [POS_W-1:0]    pos;
		logic [CNT_W-1:0]    ticks;
		logic [PERIOD_W-1:0] per_now;
		logic [DUTY_W-1:0]   duty_now;
		mts_res_t            tone_due [$];
		int                  errors;

		function new();
			song_len = '0;
			pos = '0;
			ticks = '0;
			per_now = '0;
			duty_now = '0;
			errors = 0;
			foreach (per_tab[i]) begin
				per_tab[i] = '0;
				dur_tab[i] = '0;
				written[i] = 0;
			end
		endfunction

		function void load_tone(logic [PERIOD_W-1:0] p);
			per_now = p;
			duty_now = p[PERIOD_W-1:1];
		endfunction

		function void count_tick();
			int t;
			int d;
			if (pos >= song_len) begin
				per_now = '0;
				duty_now = '0;
				return;
			end
			ticks = ticks + 1'b1;
			t = int'(ticks);
			d = (pos < TABLE_DEPTH_DEF) ? int'(dur_tab[pos]) : 0;
			if (t == d) begin
				per_now = '0;
			end else if (t == d + 1) begin
				pos = pos + 1'b1;
				ticks = '0;
				if (pos < song_len && pos < TABLE_DEPTH_DEF)
					load_tone(per_tab[pos]);
				else
					load_tone('0);
			end
		endfunction

		// Table entry this beat would read before anything wrote it, or -1
		function int missing_entry(tone_beat_t b);
			int t;
			if (b.op == OP_START)
				return written[0] ? -1 : 0;
			if (b.op == OP_TICK && pos < song_len) begin
				if (!written[pos])
					return int'(pos);
				t = (int'(ticks) + 1) & ((1 << CNT_W) - 1);
				if (t == int'(dur_tab[pos]) + 1 && int'(pos) + 1 < int'(song_len)
						&& !written[pos + 1])
					return int'(pos) + 1;
			end
			return -1;
		endfunction

		function void note_beat(tone_beat_t b);
			mts_res_t r;
			case (b.op)
				OP_TICK: count_tick();
				OP_WRITE: begin
					per_tab[b.entry] = b.period;
					dur_tab[b.entry] = b.ticks;
					written[b.entry] = 1;
				end
				OP_START: begin
					ticks = '0;
					pos = '0;
					load_tone(per_tab[0]);
				end
				OP_STOP: pos = song_len;
				OP_TONE: load_tone(b.period);
				default: ;
			endcase
			r.period = per_now;
			r.duty = duty_now;
			r.done = (pos >= song_len);
			tone_due.push_back(r);
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] data);
			mts_res_t got;
			mts_res_t want;
			got = data;
			if (tone_due.size() == 0) begin
				$error("result beat %h with no expectation waiting", data);
				errors++;
				return;
			end
			want = tone_due.pop_front();
			if (got.period !== want.period) begin
				$error("pwm_period: expected %0d, actual %0d", want.period, got.period);
				errors++;
			end
			if (got.duty !== want.duty) begin
				$error("pwm_duty: expected %0d, actual %0d", want.duty, got.duty);
				errors++;
			end
			if (got.done !== want.done) begin
				$error("song_done: expected %0d, actual %0d", want.done, got.done);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// [2:0] op, [8:3] entry_index, [24:9] tone_period, [40:25] tone_ticks, [47:41] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// [15:0] pwm_period, [30:16] pwm_duty, [31] song_done
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	tone_score score = new();
	bit src_quiet;
	bit sink_quiet;
	bit sink_hold_req;
	int idle_cycles;

	melody_tone_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Check every result beat against the oldest queued tone
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			score.check_beat(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** melody_tone_sequencer_unit: FAILED **");
			$finish;
		end
	end

	// Receiver: random stall before each beat, quiet stretches, one long hold-off
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 31) == 0)
				sink_quiet = !sink_quiet;
			if (sink_hold_req) begin
				sink_hold_req = 0;
				gap = LONG_HOLD;
			end else begin
				gap = sink_quiet ? 0 : $urandom_range(0, 6);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	task automatic push_beat(input tone_beat_t b);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		score.note_beat(b);
	endtask

	// Fill any table entry the beat would read before it was written, then send it
	task automatic send_beat(input tone_beat_t b);
		tone_beat_t fill;
		int need;
		need = score.missing_entry(b);
		while (need >= 0) begin
			fill = '0;
			fill.op = OP_WRITE;
			fill.entry = need[IDX_W-1:0];
			fill.period = PERIOD_W'($urandom);
			fill.ticks = TICKS_W'($urandom_range(0, 3));
			push_beat(fill);
			need = score.missing_entry(b);
		end
		push_beat(b);
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] entry,
			input logic [PERIOD_W-1:0] period, input logic [TICKS_W-1:0] ticks);
		tone_beat_t b;
		b = '0;
		b.op = op;
		b.entry = entry;
		b.period = period;
		b.ticks = ticks;
		send_beat(b);
	endtask

	// Drop valid and wait until every queued tone has come back
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (score.tone_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write_len(input logic [POS_W-1:0] len);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LEN_ADDR;
		pwdata <= {{(APB_DW-POS_W){1'b0}}, len};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		score.song_len = len;
		// read back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(APB_DW-POS_W){1'b0}}, len}) begin
			$error("song_length: expected %0d, actual %0d", len, prdata);
			score.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic tone_beat_t rand_beat();
		tone_beat_t b;
		int k;
		int top;
		b = '0;
		k = $urandom_range(0, 99);
		top = (score.song_len > 1) ? int'(score.song_len) - 1 : 0;
		b.entry = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, top)) : IDX_W'($urandom);
		b.period = PERIOD_W'($urandom);
		b.ticks = ($urandom_range(0, 9) < 8) ? TICKS_W'($urandom_range(0, 3)) : TICKS_W'($urandom);
		if (k < 58)
			b.op = OP_TICK;
		else if (k < 72)
			b.op = OP_WRITE;
		else if (k < 80)
			b.op = OP_START;
		else if (k < 85)
			b.op = OP_STOP;
		else if (k < 94)
			b.op = OP_TONE;
		else
			b.op = OP_TONE + OP_W'($urandom_range(1, 3));
		return b;
	endfunction

	initial begin
		tone_beat_t b;
		logic [POS_W-1:0] len;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		src_quiet = 0;
		sink_quiet = 0;
		sink_hold_req = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty song: ticks stay silent, single tone, unused ops
		send_op(OP_TICK, '1, '1, '1);
		send_op(OP_TONE, '0, 16'hFFFF, '0);
		send_op(OP_TONE + 3'd1, IDX_W'($urandom), PERIOD_W'($urandom), TICKS_W'($urandom));
		send_op(OP_TONE + 3'd3, IDX_W'($urandom), PERIOD_W'($urandom), TICKS_W'($urandom));
		send_op(OP_WRITE, 6'd0, 16'hFFFF, 16'd2);
		send_op(OP_WRITE, 6'd1, 16'h0001, 16'd0);
		send_op(OP_WRITE, 6'd2, 16'h0000, 16'd1);
		send_op(OP_WRITE, 6'd63, 16'h5555, 16'hFFFF);
		// start with empty song loads entry 0, next tick silences it
		send_op(OP_START, '0, '0, '0);
		send_op(OP_TICK, '0, '0, '0);
		wait_drained();
		apb_write_len(7'd3);
		send_op(OP_START, '0, '0, '0);
		send_op(OP_TONE, '0, 16'h1234, '0);
		// gap, advance, zero-length note, advance past the end
		repeat (7) send_op(OP_TICK, '0, '0, '0);
		send_op(OP_START, '0, '0, '0);
		send_op(OP_TICK, '0, '0, '0);
		send_op(OP_STOP, '0, '0, '0);
		send_op(OP_TICK, '0, '0, '0);

		for (int ph = 0; ph < 10; ph++) begin
			wait_drained();
			case (ph)
				0: len = 7'd64;
				1: len = 7'd0;
				2: len = 7'd1;
				default: len = ($urandom_range(0, 3) == 0) ? 7'd64 : POS_W'($urandom_range(1, 8));
			endcase
			apb_write_len(len);
			b = rand_beat();
			b.op = OP_START;
			send_beat(b);
			for (int n = 0; n < 48; n++) begin
				if (ph == 3 && n == 10) begin
					// keep offering while the receiver holds off
					src_quiet = 1;
					sink_hold_req = 1;
				end else if (!(ph == 3 && n < 30) && $urandom_range(0, 23) == 0) begin
					src_quiet = !src_quiet;
				end
				if (ph == 5 && n == 24)
					wait_drained();
				send_beat(rand_beat());
			end
		end

		wait_drained();
		if (score.errors == 0 && score.tone_due.size() == 0)
			$display("** melody_tone_sequencer_unit: PASSED **");
		else
			$display("** melody_tone_sequencer_unit: FAILED **");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mts_pkg.sv
rtl/core/mts_table.sv
rtl/core/mts_exec.sv
rtl/core/melody_tone_sequencer_unit.sv
tb/melody_tone_sequencer_unit_tb.sv
